// ===== sv/cbba_pkg.sv =====
// Package: shared constants, codes and types of the chunked aligned bump allocator.
`default_nettype none
package cbba_pkg;

  localparam int unsigned DEF_CHUNKS             = 4;
  localparam int unsigned DEF_FIRST_HEADER_BYTES = 32;
  localparam int unsigned DEF_NODE_HEADER_BYTES  = 16;

  localparam int unsigned SLOTS     = 4;
  localparam int unsigned IDX_W     = 2;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned ALIGN_W   = 4;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned ACC_W     = 34;
  localparam int unsigned PADDR_W   = 5;

  localparam logic [ACC_W-1:0] ADDR_LIMIT = 34'h1_0000_0000;

  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RESET = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

  localparam logic [1:0] ALU_ADD       = 2'd0;
  localparam logic [1:0] ALU_SUB       = 2'd1;
  localparam logic [1:0] ALU_ADD_ALIGN = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [MASK_W-1:0] mask;
  } alu_ctl_t;

endpackage
`default_nettype wire

// ===== sv/cbba_if.sv =====
// Interfaces: request and response channels of the allocator.
`default_nettype none
interface cbba_req_if;
  import cbba_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [WORD_W-1:0]   alloc_size;
  logic [ALIGN_W-1:0]  align_log2;

  modport source (output valid, action, alloc_size, align_log2, input ready);
  modport sink   (input valid, action, alloc_size, align_log2, output ready);
endinterface

interface cbba_rsp_if;
  import cbba_pkg::*;
  logic              valid;
  logic              ready;
  logic              granted;
  logic [WORD_W-1:0] region_addr;
  logic [WORD_W-1:0] free_bytes;

  modport source (output valid, granted, region_addr, free_bytes, input ready);
  modport sink   (input valid, granted, region_addr, free_bytes, output ready);
endinterface
`default_nettype wire

// ===== sv/cbba_alu.sv =====
// Shared 34-bit add / subtract / align-round unit of the allocator sequencer.
`default_nettype none
module cbba_alu (
  input  wire cbba_pkg::alu_ctl_t          ctl,
  input  wire logic [cbba_pkg::ACC_W-1:0]  a,
  input  wire logic [cbba_pkg::ACC_W-1:0]  b,
  output logic      [cbba_pkg::ACC_W-1:0]  y
);
  import cbba_pkg::*;

  logic [ACC_W-1:0] sum;
  logic [ACC_W-1:0] mask_ext;

  assign mask_ext = {{(ACC_W-MASK_W){1'b0}}, ctl.mask};

  always_comb begin
    unique case (ctl.op)
      ALU_SUB:       sum = a - b;
      default:       sum = a + b;
    endcase
    y = (ctl.op == ALU_ADD_ALIGN) ? (sum & ~mask_ext) : sum;
  end

endmodule
`default_nettype wire

// ===== sv/chunked_aligned_bump_allocator_core.sv =====
// Top level: chunked aligned bump allocator with APB configuration port.
//
// Usage: items arrive on in_if (action, alloc_size, align_log2) and one result
// per item leaves on out_if (granted, region_addr, free_bytes). Chunk bases and
// sizes are APB registers at byte address 4*i (bases 0..3, sizes 4..7).
// One item is worked at a time by a small sequencer around one shared 34-bit
// adder. An allocate passes each present chunk it examines through chunk end,
// free address, alignment round-up and fit check, and each absent chunk
// through chunk end only, plus a commit step on success. Every item ends with
// the free-byte read of the current chunk and the load of the output register.
// in_if.ready is high only when the sequencer is idle; a finished result
// sits in the output register, so the next item is taken while it waits.
// If the receiver stalls with a result still held, the sequencer waits
// before writing the next one.
// Reset clears the chunk registers, sets every chunk's use to its header size
// and makes chunk 0 current.
`default_nettype none
module chunked_aligned_bump_allocator_core #(
  parameter int unsigned CHUNKS             = cbba_pkg::DEF_CHUNKS,
  parameter int unsigned FIRST_HEADER_BYTES = cbba_pkg::DEF_FIRST_HEADER_BYTES,
  parameter int unsigned NODE_HEADER_BYTES  = cbba_pkg::DEF_NODE_HEADER_BYTES
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  cbba_req_if.sink                            in_if,
  cbba_rsp_if.source                          out_if,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [cbba_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [cbba_pkg::WORD_W-1:0]    pwdata,
  output logic      [cbba_pkg::WORD_W-1:0]    prdata,
  output logic                                pready
);
  import cbba_pkg::*;

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(CHUNKS - 1);
  localparam logic [WORD_W-1:0] HDR_FIRST = WORD_W'(FIRST_HEADER_BYTES);
  localparam logic [WORD_W-1:0] HDR_NODE  = WORD_W'(NODE_HEADER_BYTES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_END    = 3'd1;
  localparam logic [2:0] S_FREE   = 3'd2;
  localparam logic [2:0] S_ALIGN  = 3'd3;
  localparam logic [2:0] S_TAIL   = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;
  localparam logic [2:0] S_QUERY  = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [WORD_W-1:0]  base_r  [SLOTS];
  logic [WORD_W-1:0]  bytes_r [SLOTS];
  logic [WORD_W-1:0]  used_r  [SLOTS];

  logic [2:0]         state_r;
  logic [IDX_W-1:0]   k_r;
  logic [IDX_W-1:0]   cur_r;
  logic [WORD_W-1:0]  size_r;
  logic [ALIGN_W-1:0] align_r;
  logic [ACC_W-1:0]   end_r;
  logic [ACC_W-1:0]   acc_r;
  logic               granted_r;
  logic [WORD_W-1:0]  addr_r;

  logic               out_valid_r;
  logic               out_granted_r;
  logic [WORD_W-1:0]  out_addr_r;
  logic [WORD_W-1:0]  out_free_r;

  alu_ctl_t           alu_ctl;
  logic [ACC_W-1:0]   alu_a;
  logic [ACC_W-1:0]   alu_b;
  logic [ACC_W-1:0]   alu_y;

  logic [MASK_W-1:0]  mask;
  logic [WORD_W-1:0]  hdr_k;
  logic               present_k;
  logic               fit;
  logic               in_fire;
  logic               cfg_wr;
  logic               out_load;

  assign mask      = ~(MASK_W'({MASK_W{1'b1}}) << align_r);
  assign hdr_k     = (k_r == '0) ? HDR_FIRST : HDR_NODE;
  assign present_k = bytes_r[k_r] > hdr_k;
  assign fit       = (acc_r < ADDR_LIMIT) && (alu_y <= end_r);
  assign in_fire   = in_if.valid && in_if.ready;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_if.ready);

  assign in_if.ready        = (state_r == S_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.granted     = out_granted_r;
  assign out_if.region_addr = out_addr_r;
  assign out_if.free_bytes  = out_free_r;

  assign pready = 1'b1;
  assign prdata = paddr[PADDR_W-1] ? bytes_r[paddr[PADDR_W-2:2]] : base_r[paddr[PADDR_W-2:2]];

  always_comb begin
    alu_ctl.op   = ALU_ADD;
    alu_ctl.mask = mask;
    alu_a        = {2'b00, base_r[k_r]};
    alu_b        = {2'b00, bytes_r[k_r]};
    unique case (state_r)
      S_FREE: begin
        alu_b = {2'b00, used_r[k_r]};
      end
      S_ALIGN: begin
        alu_ctl.op = ALU_ADD_ALIGN;
        alu_a      = acc_r;
        alu_b      = {{(ACC_W-MASK_W){1'b0}}, mask};
      end
      S_TAIL: begin
        alu_a = acc_r;
        alu_b = {2'b00, size_r};
      end
      S_COMMIT: begin
        alu_ctl.op = ALU_SUB;
        alu_a      = acc_r;
        alu_b      = {2'b00, base_r[k_r]};
      end
      S_QUERY: begin
        alu_ctl.op = ALU_SUB;
        alu_a      = {2'b00, bytes_r[k_r]};
        alu_b      = {2'b00, used_r[k_r]};
      end
      default: begin
      end
    endcase
  end

  cbba_alu u_alu (
    .ctl (alu_ctl),
    .a   (alu_a),
    .b   (alu_b),
    .y   (alu_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        base_r[i]  <= '0;
        bytes_r[i] <= '0;
        used_r[i]  <= (i == 0) ? HDR_FIRST : HDR_NODE;
      end
      state_r     <= S_IDLE;
      k_r         <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[PADDR_W-1]) begin
          bytes_r[paddr[PADDR_W-2:2]] <= pwdata;
        end else begin
          base_r[paddr[PADDR_W-2:2]] <= pwdata;
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            size_r    <= in_if.alloc_size;
            align_r   <= in_if.align_log2;
            addr_r    <= '0;
            granted_r <= 1'b1;
            if (in_if.action == ACT_ALLOC) begin
              granted_r <= 1'b0;
              k_r       <= cur_r;
              state_r   <= S_END;
            end else if (in_if.action == ACT_RESET) begin
              for (int i = 0; i < SLOTS; i++) begin
                used_r[i] <= (i == 0) ? HDR_FIRST : HDR_NODE;
              end
              cur_r   <= '0;
              k_r     <= '0;
              state_r <= S_QUERY;
            end else begin
              k_r     <= cur_r;
              state_r <= S_QUERY;
            end
          end
        end
        S_END: begin
          end_r <= (alu_y > ADDR_LIMIT) ? ADDR_LIMIT : alu_y;
          if (present_k) begin
            state_r <= S_FREE;
          end else if (k_r == LAST_IDX) begin
            k_r     <= cur_r;
            state_r <= S_QUERY;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_FREE: begin
          acc_r   <= alu_y;
          state_r <= S_ALIGN;
        end
        S_ALIGN: begin
          acc_r   <= alu_y;
          state_r <= S_TAIL;
        end
        S_TAIL: begin
          if (fit) begin
            addr_r  <= acc_r[WORD_W-1:0];
            acc_r   <= alu_y;
            state_r <= S_COMMIT;
          end else if (k_r == LAST_IDX) begin
            k_r     <= cur_r;
            state_r <= S_QUERY;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_END;
          end
        end
        S_COMMIT: begin
          used_r[k_r] <= alu_y[WORD_W-1:0];
          cur_r       <= k_r;
          granted_r   <= 1'b1;
          state_r     <= S_QUERY;
        end
        S_QUERY: begin
          acc_r   <= alu_y[ACC_W-1] ? '0 : alu_y;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_granted_r <= granted_r;
      out_addr_r    <= addr_r;
      out_free_r    <= acc_r[WORD_W-1:0];
    end
  end

  a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= LAST_IDX)
    else $error("current chunk beyond configured count");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.granted |-> out_if.region_addr == '0)
    else $error("failed allocate carries an address");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_if.ready)
    else $error("item accepted while previous one still in work");

  a_commit_fits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COMMIT |-> acc_r <= end_r && addr_r < acc_r + 1'b1 + size_r)
    else $error("committed region exceeds chunk end");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_valid_r && !out_if.ready |=> state_r == S_OUT)
    else $error("result dropped while receiver stalled");

endmodule
`default_nettype wire
